// ----- src/glmrs_pkg.sv -----
`timescale 1ns / 1ps
package glmrs_pkg;

  localparam int HEIGHT_W = 4;
  localparam int RISK_W   = 18;
  localparam int COUNT_W  = 15;
  localparam int ROWLEN_W = 8;

  localparam logic [RISK_W-1:0]   RISK_MAX  = {RISK_W{1'b1}};
  localparam logic [COUNT_W-1:0]  COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [ROWLEN_W-1:0] ROW_LENGTH_RESET = 8'd128;

  // Word index of the configuration registers.
  localparam logic REG_ROW_LENGTH = 1'b0;

  // Scan step of one cell: the first five issue a memory read, the last one
  // consumes the final neighbor and updates the totals.
  typedef enum logic [2:0] {
    PH_CENTER = 3'd0,
    PH_UP     = 3'd1,
    PH_DOWN   = 3'd2,
    PH_LEFT   = 3'd3,
    PH_RIGHT  = 3'd4,
    PH_EVAL   = 3'd5
  } phase_t;

  typedef struct packed {
    logic   load;
    logic   start;
    logic   scan;
    phase_t phase;
    logic   publish;
  } glmrs_cmd_t;

  typedef struct packed {
    logic last_cell;
    logic out_free;
  } glmrs_status_t;

endpackage

// ----- src/glmrs_ram.sv -----
`timescale 1ns / 1ps
module glmrs_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16384,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- src/glmrs_ctrl.sv -----
`timescale 1ns / 1ps
module glmrs_ctrl
  import glmrs_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  input  logic          s_tlast,
  output logic          s_tready,
  input  glmrs_status_t status,
  output glmrs_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t state;
  phase_t phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      phase    <= PH_CENTER;
      s_tready <= 1'b1;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (s_tvalid && s_tready && s_tlast) begin
            state    <= ST_SCAN;
            phase    <= PH_CENTER;
            s_tready <= 1'b0;
          end
        end
        ST_SCAN: begin
          unique case (phase)
            PH_CENTER: phase <= PH_UP;
            PH_UP:     phase <= PH_DOWN;
            PH_DOWN:   phase <= PH_LEFT;
            PH_LEFT:   phase <= PH_RIGHT;
            PH_RIGHT:  phase <= PH_EVAL;
            PH_EVAL: begin
              phase <= PH_CENTER;
              if (status.last_cell) begin
                state <= ST_FINISH;
              end
            end
            default:   phase <= PH_CENTER;
          endcase
        end
        ST_FINISH: begin
          if (status.out_free) begin
            state    <= ST_LOAD;
            s_tready <= 1'b1;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  always_comb begin
    cmd.load    = (state == ST_LOAD) && s_tready && s_tvalid;
    cmd.start   = cmd.load && s_tlast;
    cmd.scan    = (state == ST_SCAN);
    cmd.phase   = phase;
    cmd.publish = (state == ST_FINISH) && status.out_free;
  end

endmodule

// ----- src/glmrs_dp.sv -----
`timescale 1ns / 1ps
module glmrs_dp
  import glmrs_pkg::*;
#(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  glmrs_cmd_t          cmd,
  output glmrs_status_t       status,
  input  logic [HEIGHT_W-1:0] height,
  input  logic [ROWLEN_W-1:0] row_length,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [RISK_W-1:0]   risk_sum,
  output logic [COUNT_W-1:0]  low_point_count,
  output logic                overflow
);

  localparam int CAPACITY = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int W_W      = $clog2(MAX_COLS + 1);
  localparam int SUM_W    = CNT_W + 1;

  logic [CNT_W-1:0]    cells_loaded;
  logic                dropped;
  logic [W_W-1:0]      width;
  logic [CNT_W-1:0]    cell_idx;
  logic [W_W-1:0]      col;
  logic [HEIGHT_W-1:0] h_cur;
  logic                low;
  logic                pres_q;
  logic [RISK_W-1:0]   risk_total;
  logic [COUNT_W-1:0]  minima_total;

  logic [W_W-1:0]      width_next;
  logic [SUM_W-1:0]    cell_x, width_x, n_x, col_x, addr_sum;
  logic                pres;
  logic                has_room;
  logic                nb_ok;
  logic [RISK_W:0]     risk_add;
  logic [HEIGHT_W-1:0] rd_data;

  // Geometry taken from the row length in force when the grid ends.
  always_comb begin
    if (row_length == '0) begin
      width_next = W_W'(1);
    end else if (32'(row_length) > 32'(MAX_COLS)) begin
      width_next = W_W'(MAX_COLS);
    end else begin
      width_next = W_W'(row_length);
    end
  end

  assign has_room = (32'(cells_loaded) < 32'(CAPACITY));
  assign cell_x   = SUM_W'(cell_idx);
  assign width_x  = SUM_W'(width);
  assign n_x      = SUM_W'(cells_loaded);
  assign col_x    = SUM_W'(col);

  // Neighbor address and presence for the read issued in this step.
  always_comb begin
    case (cmd.phase)
      PH_UP: begin
        addr_sum = cell_x - width_x;
        pres     = (cell_x >= width_x);
      end
      PH_DOWN: begin
        addr_sum = cell_x + width_x;
        pres     = (cell_x + width_x < n_x);
      end
      PH_LEFT: begin
        addr_sum = cell_x - SUM_W'(1);
        pres     = (col != '0);
      end
      PH_RIGHT: begin
        addr_sum = cell_x + SUM_W'(1);
        pres     = (col_x + SUM_W'(1) < width_x) && (cell_x + SUM_W'(1) < n_x);
      end
      default: begin
        addr_sum = cell_x;
        pres     = 1'b1;
      end
    endcase
  end

  glmrs_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (CAPACITY)
  ) u_height_store (
    .clk     (clk),
    .wr_en   (cmd.load && has_room),
    .wr_addr (cells_loaded[ADDR_W-1:0]),
    .wr_data (height),
    .rd_addr (addr_sum[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // Read data arrives in the cycle after its address is issued, and so does its presence.
  assign nb_ok    = !pres_q || (rd_data > h_cur);
  assign risk_add = {1'b0, risk_total} + (RISK_W+1)'(h_cur) + (RISK_W+1)'(1);

  assign status.last_cell = (cell_x + SUM_W'(1) == n_x);
  assign status.out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_loaded <= '0;
      dropped      <= 1'b0;
      risk_total   <= '0;
      minima_total <= '0;
      m_tvalid     <= 1'b0;
      pres_q       <= 1'b0;
    end else begin
      pres_q <= pres;

      if (cmd.load) begin
        if (has_room) begin
          cells_loaded <= cells_loaded + CNT_W'(1);
        end else begin
          dropped <= 1'b1;
        end
      end

      if (cmd.start) begin
        risk_total   <= '0;
        minima_total <= '0;
      end

      if (cmd.scan && cmd.phase == PH_EVAL && low && nb_ok) begin
        risk_total <= risk_add[RISK_W] ? RISK_MAX : risk_add[RISK_W-1:0];
        if (minima_total != COUNT_MAX) begin
          minima_total <= minima_total + COUNT_W'(1);
        end
      end

      if (cmd.publish) begin
        m_tvalid     <= 1'b1;
        cells_loaded <= '0;
        dropped      <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      width    <= width_next;
      cell_idx <= '0;
      col      <= '0;
    end

    if (cmd.scan) begin
      case (cmd.phase)
        PH_UP: begin
          h_cur <= rd_data;
          low   <= 1'b1;
        end
        PH_DOWN, PH_LEFT, PH_RIGHT: begin
          low <= low && nb_ok;
        end
        PH_EVAL: begin
          cell_idx <= cell_idx + CNT_W'(1);
          col      <= (col + W_W'(1) == width) ? '0 : col + W_W'(1);
        end
        default: begin
        end
      endcase
    end

    if (cmd.publish) begin
      risk_sum        <= risk_total;
      low_point_count <= minima_total;
      overflow        <= dropped;
    end
  end

endmodule

// ----- src/grid_local_minimum_risk_sum.sv -----
`timescale 1ns / 1ps
// Four-neighbor low point finder over a height map streamed in raster order.
//
// Input stream: one cell per transfer, height in s_tdata[3:0], s_tlast on the
// final cell of the grid. Loading writes each accepted cell to the height
// store; cells past MAX_COLS * MAX_ROWS are dropped and flagged.
// The transfer with s_tlast starts a scan of all n stored cells. Each cell
// has six steps: five reads through the single read port of the height
// store (the cell and its four neighbors) and one step to update the totals.
// The result is presented after the scan of the last stored cell, and s_tready
// is low during the scan. The result waits in an output register, so loading
// of the next grid goes on while the receiver stalls; only the end of the
// next scan waits for the register to empty.
// The row_length register (APB, address 0) sets the grid width and may only
// be written while no grid is in flight. Reset sets row_length to 128, empties
// the loader and the output register; the height store needs no clearing.
module grid_local_minimum_risk_sum
  import glmrs_pkg::*;
#(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [3:0] height
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [17:0] risk_sum, [32:18] low_point_count, [33] overflow
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [ROWLEN_W-1:0] row_length;
  glmrs_cmd_t          cmd;
  glmrs_status_t       status;
  logic [RISK_W-1:0]   risk_sum;
  logic [COUNT_W-1:0]  low_point_count;
  logic                overflow;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= ROW_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ROW_LENGTH) begin
      row_length <= pwdata[ROWLEN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ROW_LENGTH) ? 32'(row_length) : '0;

  glmrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  glmrs_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .height          (s_tdata[HEIGHT_W-1:0]),
    .row_length      (row_length),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .risk_sum        (risk_sum),
    .low_point_count (low_point_count),
    .overflow        (overflow)
  );

  assign m_tdata = {6'b0, overflow, low_point_count, risk_sum};

  // The scan starts right after the final cell, so the input must close.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("input still open after the final cell");

  // A new result is only produced at the end of a scan.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared outside a scan");

  // Every low point adds at least one to the risk sum.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[17:0] >= {3'b0, m_tdata[32:18]}))
    else $error("risk sum below low point count");

endmodule
